// ===== rtl/pipeline_hazard_stall_scoreboard_unit_macros.svh =====
// Assertion macros shared by the hazard scoreboard RTL.
`ifndef PIPELINE_HAZARD_STALL_SCOREBOARD_UNIT_MACROS_SVH
`define PIPELINE_HAZARD_STALL_SCOREBOARD_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PHSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phss: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PHSS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phss: next-cycle check failed");

`endif

// ===== rtl/phss_pkg.sv =====
// Shared types and constants of the hazard scoreboard.
package phss_pkg;

    localparam int REG_IDX_W = 5;
    localparam int OUT_CYC_W = 32;
    localparam int STALL_W   = 2;
    localparam logic [STALL_W-1:0] STALL_MAX = 2'd3;

    typedef struct packed {
        logic                 src_a_valid;
        logic [REG_IDX_W-1:0] src_a_index;
        logic                 src_b_valid;
        logic [REG_IDX_W-1:0] src_b_index;
        logic                 dest_valid;
        logic [REG_IDX_W-1:0] dest_index;
        logic                 is_memory;
        logic                 is_load;
    } in_word_t;

    typedef struct packed {
        logic [OUT_CYC_W-1:0] fetch_cycle;
        logic [OUT_CYC_W-1:0] decode_cycle;
        logic [OUT_CYC_W-1:0] execute_cycle;
        logic [OUT_CYC_W-1:0] memory_cycle;
        logic [OUT_CYC_W-1:0] writeback_cycle;
        logic [STALL_W-1:0]   stall_count;
    } out_word_t;

    // Scoreboard update strobes from the timing logic.
    typedef struct packed {
        logic mem_we;
        logic reg_we;
    } upd_ctl_t;

endpackage

// ===== rtl/phss_regfile.sv =====
// Register ready-cycle memory: two registered reads, one write, reset via valid bits.
module phss_regfile import phss_pkg::*;
#(
    parameter int NUM_REGS    = 32,
    parameter int CYCLE_WIDTH = 32,
    localparam int IDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_a_addr,
    input  logic [IDX_W-1:0]       rd_b_addr,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  logic [CYCLE_WIDTH-1:0] wr_data,
    output logic [CYCLE_WIDTH-1:0] rd_a_data,
    output logic [CYCLE_WIDTH-1:0] rd_b_data
);

    logic [CYCLE_WIDTH-1:0] ram [NUM_REGS];
    logic [NUM_REGS-1:0]    vld_reg;
    logic [CYCLE_WIDTH-1:0] ram_a_reg;
    logic [CYCLE_WIDTH-1:0] ram_b_reg;
    logic [CYCLE_WIDTH-1:0] byp_data_reg;
    logic                   byp_a_reg;
    logic                   byp_b_reg;
    logic                   hit_a_reg;
    logic                   hit_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            ram_a_reg <= ram[rd_a_addr];
            ram_b_reg <= ram[rd_b_addr];
        end
    end

    // Same-cycle write wins over the stored word.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_a_reg    <= wr_en && (wr_addr == rd_a_addr);
            byp_b_reg    <= wr_en && (wr_addr == rd_b_addr);
            hit_a_reg    <= vld_reg[rd_a_addr];
            hit_b_reg    <= vld_reg[rd_b_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_a_data = byp_a_reg ? byp_data_reg : (hit_a_reg ? ram_a_reg : '0);
    assign rd_b_data = byp_b_reg ? byp_data_reg : (hit_b_reg ? ram_b_reg : '0);

endmodule

// ===== rtl/phss_calc.sv =====
// Stall and stage-cycle computation with saturating cycle arithmetic.
module phss_calc import phss_pkg::*;
#(
    parameter int NUM_REGS    = 32,
    parameter int CYCLE_WIDTH = 32
)
(
    input  in_word_t               item,
    input  logic [CYCLE_WIDTH-1:0] src_a_ready,
    input  logic [CYCLE_WIDTH-1:0] src_b_ready,
    input  logic [CYCLE_WIDTH-1:0] mem_ready,
    input  logic [CYCLE_WIDTH-1:0] last_fetch,
    output out_word_t              result,
    output upd_ctl_t               ctl,
    output logic [CYCLE_WIDTH-1:0] next_fetch,
    output logic [CYCLE_WIDTH-1:0] next_mem_ready,
    output logic [CYCLE_WIDTH-1:0] reg_wr_data
);

    localparam int EXT_W = ((REG_IDX_W > $clog2(NUM_REGS)) ? REG_IDX_W : $clog2(NUM_REGS)) + 1;
    localparam logic [EXT_W-1:0] NREG = EXT_W'(NUM_REGS);

    function automatic logic [CYCLE_WIDTH-1:0] sat_add(input logic [CYCLE_WIDTH-1:0] a,
                                                       input logic [CYCLE_WIDTH-1:0] b);
        logic [CYCLE_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CYCLE_WIDTH] ? '1 : s[CYCLE_WIDTH-1:0];
    endfunction

    // Cycles still missing until ready, clipped to the stall range.
    function automatic logic [STALL_W-1:0] need_for(input logic [CYCLE_WIDTH-1:0] at,
                                                    input logic [CYCLE_WIDTH-1:0] rdy);
        logic [CYCLE_WIDTH-1:0] d;
        d = rdy - at;
        if (rdy <= at)
            return '0;
        else if (d > CYCLE_WIDTH'(STALL_MAX))
            return STALL_MAX;
        else
            return d[STALL_W-1:0];
    endfunction

    logic                   a_use, b_use, d_use;
    logic [CYCLE_WIDTH-1:0] fc0, dc0, mc0;
    logic [CYCLE_WIDTH-1:0] fc, dc, ec, mc, wc;
    logic [STALL_W-1:0]     n_a, n_b, n_m, stall;

    always_comb
    begin
        a_use = item.src_a_valid && (EXT_W'(item.src_a_index) < NREG);
        b_use = item.src_b_valid && (EXT_W'(item.src_b_index) < NREG);
        d_use = item.dest_valid  && (EXT_W'(item.dest_index)  < NREG);

        // Saturating offsets compose, so each is taken straight from last fetch.
        fc0 = sat_add(last_fetch, CYCLE_WIDTH'(1));
        dc0 = sat_add(last_fetch, CYCLE_WIDTH'(2));
        mc0 = sat_add(last_fetch, CYCLE_WIDTH'(4));

        n_a = a_use ? need_for(dc0, src_a_ready) : '0;
        n_b = b_use ? need_for(dc0, src_b_ready) : '0;
        n_m = item.is_memory ? need_for(mc0, mem_ready) : '0;
        stall = n_a;
        if (n_b > stall)
            stall = n_b;
        if (n_m > stall)
            stall = n_m;

        fc = sat_add(fc0, CYCLE_WIDTH'(stall));
        dc = sat_add(fc, CYCLE_WIDTH'(1));
        ec = sat_add(fc, CYCLE_WIDTH'(2));
        mc = sat_add(fc, CYCLE_WIDTH'(3));
        wc = sat_add(fc, CYCLE_WIDTH'(4));

        result.fetch_cycle     = OUT_CYC_W'(fc);
        result.decode_cycle    = OUT_CYC_W'(dc);
        result.execute_cycle   = OUT_CYC_W'(ec);
        result.memory_cycle    = OUT_CYC_W'(mc);
        result.writeback_cycle = OUT_CYC_W'(wc);
        result.stall_count     = stall;

        // MEM + 1 is the writeback cycle, EX + 1 is the memory cycle.
        ctl.mem_we     = item.is_memory;
        ctl.reg_we     = d_use;
        next_fetch     = fc;
        next_mem_ready = wc;
        reg_wr_data    = item.is_load ? wc : mc;
    end

endmodule

// ===== rtl/pipeline_hazard_stall_scoreboard_unit.sv =====
// Top level of the five-stage pipeline hazard scoreboard.
//
//  channel   direction  word          handshake
//  item      in         in_word_t     item_valid / item_ready
//  result    out        out_word_t    result_valid / result_ready
//
// One word per cycle sustained while result_ready stays high; each word
// is registered into the lookup stage (register ready-cycle memory read)
// and is then scored and written into the result register, updating the
// scoreboard at the same edge. Reset clears the ready valid bits, memory
// ready and last fetch cycle; no clearing pass is needed. A held result
// stalls the lookup stage, which in turn holds item_ready low.
module pipeline_hazard_stall_scoreboard_unit import phss_pkg::*;
#(
    parameter int NUM_REGS    = 32,
    parameter int CYCLE_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result
);

`include "pipeline_hazard_stall_scoreboard_unit_macros.svh"

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // Lookup stage holding the word whose source ready cycles are being read.
    logic                   stage_valid_reg;
    in_word_t               stage_item_reg;
    // Result register.
    logic                   result_valid_reg;
    out_word_t              result_reg;
    // Scoreboard scalars.
    logic [CYCLE_WIDTH-1:0] mem_ready_reg;
    logic [CYCLE_WIDTH-1:0] last_fetch_reg;

    logic                   accept;
    logic                   advance;
    logic [CYCLE_WIDTH-1:0] src_a_ready, src_b_ready;
    out_word_t              calc_result;
    upd_ctl_t               calc_ctl;
    logic [CYCLE_WIDTH-1:0] next_fetch, next_mem_ready, reg_wr_data;
    logic                   reg_we;

    // The stage moves on whenever the result register is empty or draining.
    assign advance    = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;
    assign accept     = item_valid && item_ready;
    assign reg_we     = advance && calc_ctl.reg_we;

    phss_regfile #(
        .NUM_REGS    (NUM_REGS),
        .CYCLE_WIDTH (CYCLE_WIDTH)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_a_addr (IDX_W'(item.src_a_index)),
        .rd_b_addr (IDX_W'(item.src_b_index)),
        .wr_en     (reg_we),
        .wr_addr   (IDX_W'(stage_item_reg.dest_index)),
        .wr_data   (reg_wr_data),
        .rd_a_data (src_a_ready),
        .rd_b_data (src_b_ready)
    );

    phss_calc #(
        .NUM_REGS    (NUM_REGS),
        .CYCLE_WIDTH (CYCLE_WIDTH)
    ) u_calc (
        .item           (stage_item_reg),
        .src_a_ready    (src_a_ready),
        .src_b_ready    (src_b_ready),
        .mem_ready      (mem_ready_reg),
        .last_fetch     (last_fetch_reg),
        .result         (calc_result),
        .ctl            (calc_ctl),
        .next_fetch     (next_fetch),
        .next_mem_ready (next_mem_ready),
        .reg_wr_data    (reg_wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            mem_ready_reg    <= '0;
            last_fetch_reg   <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                stage_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                last_fetch_reg   <= next_fetch;
                if (calc_ctl.mem_we)
                begin
                    mem_ready_reg <= next_mem_ready;
                end
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= calc_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A word is never taken while the lookup stage is full and stuck.
    `PHSS_ASSERT_IMP(a_no_overwrite, accept, !stage_valid_reg || advance)
    // A blocked stage keeps its word.
    `PHSS_ASSERT_NXT(a_stage_hold, stage_valid_reg && !advance, stage_valid_reg)
    // Fetch cycle moves forward on every issued word, or sits saturated.
    `PHSS_ASSERT_NXT(a_fetch_fwd, advance,
        (last_fetch_reg > $past(last_fetch_reg)) || (&last_fetch_reg))

endmodule

// ===== dv/pipeline_hazard_stall_scoreboard_unit_tb.sv =====
// Self-checking testbench for the five-stage pipeline hazard scoreboard.
module pipeline_hazard_stall_scoreboard_unit_tb;
    import phss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Match the DUT defaults; the predictor is written against these.
    localparam int NUM_SCORE_REGS = 32;
    localparam int CYC_W          = 32;
    localparam int CLK_HALF       = 5;
    localparam int IN_W           = $bits(in_word_t);

    // Word counts per test, and the length of the result hold-off.
    localparam int RANDOM_WORDS   = 365;
    localparam int PRESSURE_WORDS = 40;
    localparam int HOLD_CYCLES    = 150;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    in_word_t  item;
    logic      result_valid;
    logic      result_ready;
    out_word_t result;

    pipeline_hazard_stall_scoreboard_unit #(
        .NUM_REGS    (NUM_SCORE_REGS),
        .CYCLE_WIDTH (CYC_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // Predictor state: ready cycle per register, memory free cycle, and
    // the fetch cycle of the last scored instruction.
    // ------------------------------------------------------------------
    logic [CYC_W-1:0] reg_ready_cyc [NUM_SCORE_REGS];
    logic [CYC_W-1:0] mem_free_cyc;
    logic [CYC_W-1:0] prev_fetch_cyc;

    // Timing words predicted but not yet seen on the result channel.
    out_word_t pending_timings[$];

    int mismatch_count;
    int issued_count;
    int retired_count;
    int stall_seen [4];

    // Knobs shared between the test tasks and the driver processes.
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_request;
    int hold_left;

    // Recently written destinations, used to build dependent chains.
    logic [REG_IDX_W-1:0] recent_dest [4];

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Hard stop in case the handshake hangs; far above the slowest pass.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [CYC_W-1:0] sat_add(logic [CYC_W-1:0] a, logic [CYC_W-1:0] b);
        logic [CYC_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CYC_W] ? {CYC_W{1'b1}} : sum[CYC_W-1:0];
    endfunction

    // Cycles needed to move 'at' up to 'ready'.
    function automatic logic [CYC_W-1:0] shortfall(logic [CYC_W-1:0] at, logic [CYC_W-1:0] ready);
        return (at < ready) ? ready - at : '0;
    endfunction

    function automatic void clear_scoreboard();
        for (int i = 0; i < NUM_SCORE_REGS; i++)
        begin
            reg_ready_cyc[i] = '0;
        end
        mem_free_cyc   = '0;
        prev_fetch_cyc = '0;
    endfunction

    // Score one instruction, update the scoreboard, return its stage timing.
    function automatic out_word_t schedule_instruction(in_word_t w);
        out_word_t        t;
        logic [CYC_W-1:0] fc;
        logic [CYC_W-1:0] dc;
        logic [CYC_W-1:0] ec;
        logic [CYC_W-1:0] mc;
        logic [CYC_W-1:0] wc;
        logic [CYC_W-1:0] stall;
        logic [CYC_W-1:0] need;

        fc    = sat_add(prev_fetch_cyc, 1);
        dc    = sat_add(fc, 1);
        mc    = sat_add(dc, 2);
        stall = '0;

        // Out-of-range sources count as unused.
        if (w.src_a_valid && int'(w.src_a_index) < NUM_SCORE_REGS)
        begin
            need = shortfall(dc, reg_ready_cyc[w.src_a_index]);
            if (need > stall)
                stall = need;
        end
        if (w.src_b_valid && int'(w.src_b_index) < NUM_SCORE_REGS)
        begin
            need = shortfall(dc, reg_ready_cyc[w.src_b_index]);
            if (need > stall)
                stall = need;
        end
        if (w.is_memory)
        begin
            need = shortfall(mc, mem_free_cyc);
            if (need > stall)
                stall = need;
        end
        if (stall > CYC_W'(STALL_MAX))
            stall = CYC_W'(STALL_MAX);

        fc = sat_add(fc, stall);
        dc = sat_add(fc, 1);
        ec = sat_add(fc, 2);
        mc = sat_add(fc, 3);
        wc = sat_add(fc, 4);

        // is_load alone only picks the dest ready time; memory needs is_memory.
        if (w.is_memory)
            mem_free_cyc = sat_add(mc, 1);
        if (w.dest_valid && int'(w.dest_index) < NUM_SCORE_REGS)
            reg_ready_cyc[w.dest_index] = w.is_load ? sat_add(mc, 1) : sat_add(ec, 1);
        prev_fetch_cyc = fc;

        t.fetch_cycle     = fc[OUT_CYC_W-1:0];
        t.decode_cycle    = dc[OUT_CYC_W-1:0];
        t.execute_cycle   = ec[OUT_CYC_W-1:0];
        t.memory_cycle    = mc[OUT_CYC_W-1:0];
        t.writeback_cycle = wc[OUT_CYC_W-1:0];
        t.stall_count     = stall[STALL_W-1:0];
        stall_seen[stall[1:0]]++;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted instruction word and checks
    // every accepted timing word against the oldest prediction. Values
    // are taken at the rising edge, before the DUT's flops update.
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        out_word_t predicted;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                retired_count++;
                if (pending_timings.size() == 0)
                begin
                    $error("timing word with no instruction outstanding: %h", result);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_timings.pop_front();
                    compare_field("fetch_cycle",     want.fetch_cycle,     result.fetch_cycle);
                    compare_field("decode_cycle",    want.decode_cycle,    result.decode_cycle);
                    compare_field("execute_cycle",   want.execute_cycle,   result.execute_cycle);
                    compare_field("memory_cycle",    want.memory_cycle,    result.memory_cycle);
                    compare_field("writeback_cycle", want.writeback_cycle, result.writeback_cycle);
                    compare_field("stall_count",     32'(want.stall_count),
                                  32'(result.stall_count));
                end
            end
            if (item_valid && item_ready)
            begin
                issued_count++;
                predicted       = schedule_instruction(item);
                pending_timings = {pending_timings, predicted};
            end
        end
    end

    // ------------------------------------------------------------------
    // Result-side driver: random backpressure, plus an explicit hold-off
    // of a given number of cycles when a test asks for one.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Instruction-side helpers
    // ------------------------------------------------------------------

    // Offer one word at the falling edge, hold it until accepted.
    task automatic issue_word(in_word_t w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= w;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
    endtask

    // Drop valid and wait until every predicted timing word has come back.
    task automatic wait_for_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_timings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic in_word_t instr(bit av, int a, bit bv, int b, bit dv, int d,
                                       bit mem, bit ld);
        in_word_t w;
        w.src_a_valid = av;
        w.src_a_index = a[REG_IDX_W-1:0];
        w.src_b_valid = bv;
        w.src_b_index = b[REG_IDX_W-1:0];
        w.dest_valid  = dv;
        w.dest_index  = d[REG_IDX_W-1:0];
        w.is_memory   = mem;
        w.is_load     = ld;
        return w;
    endfunction

    // Source index: half the time a recent destination, to force hazards.
    function automatic logic [REG_IDX_W-1:0] pick_source();
        if ($urandom_range(0, 1))
            return recent_dest[$urandom_range(0, 3)];
        return REG_IDX_W'($urandom_range(0, NUM_SCORE_REGS - 1));
    endfunction

    // Mostly plausible instructions with dependent operands; some raw noise.
    function automatic in_word_t random_instruction();
        in_word_t w;
        if ($urandom_range(0, 99) < 15)
        begin
            w = in_word_t'(IN_W'($urandom));
        end
        else
        begin
            w.src_a_valid = ($urandom_range(0, 3) != 0);
            w.src_a_index = pick_source();
            w.src_b_valid = ($urandom_range(0, 1) != 0);
            w.src_b_index = pick_source();
            w.dest_valid  = ($urandom_range(0, 4) != 0);
            w.dest_index  = REG_IDX_W'($urandom_range(0, NUM_SCORE_REGS - 1));
            w.is_memory   = ($urandom_range(0, 99) < 40);
            // loads with memory set, plus an occasional stray load flag
            w.is_load     = w.is_memory ? ($urandom_range(0, 99) < 60)
                                        : ($urandom_range(0, 99) < 10);
        end
        if (w.dest_valid)
        begin
            recent_dest[$urandom_range(0, 3)] = w.dest_index;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and each hazard kind, one at a time.
    task automatic test_directed_hazards();
        tx_idle_pct = 21;
        rx_idle_pct = 63;
        issue_word(instr(0, 0, 0, 0, 0, 0, 0, 0));       // all fields low
        issue_word(instr(1, 31, 1, 31, 1, 31, 1, 1));    // all fields high: load r31
        issue_word(instr(1, 31, 0, 0, 0, 0, 0, 0));      // load-use on r31
        issue_word(instr(0, 0, 0, 0, 1, 1, 0, 0));       // ALU writes r1
        issue_word(instr(1, 1, 0, 0, 1, 2, 0, 0));       // r1 via port A, writes r2
        issue_word(instr(0, 0, 1, 2, 0, 0, 0, 0));       // r2 via port B
        issue_word(instr(0, 0, 0, 0, 0, 5, 1, 1));       // load with dest not marked valid
        issue_word(instr(1, 5, 1, 5, 0, 0, 0, 0));       // no stall expected on r5
        issue_word(instr(0, 0, 0, 0, 1, 3, 0, 1));       // load flag without memory flag
        issue_word(instr(1, 3, 0, 0, 0, 0, 1, 0));       // waits on r3, memory not busy
        issue_word(instr(0, 0, 0, 0, 0, 0, 1, 0));       // store after store
        issue_word(instr(0, 0, 0, 0, 0, 0, 1, 0));
        issue_word(instr(0, 0, 0, 0, 1, 4, 1, 1));       // load r4
        issue_word(instr(0, 4, 0, 4, 0, 0, 0, 0));       // r4 named but unused
        issue_word(instr(0, 0, 0, 0, 1, 6, 1, 1));       // load r6
        issue_word(instr(0, 0, 0, 0, 1, 7, 0, 0));       // ALU r7
        issue_word(instr(1, 6, 1, 7, 1, 0, 0, 0));       // both sources pending, writes r0
        issue_word(instr(1, 0, 1, 0, 1, 0, 1, 1));       // r0 dependency, load to r0
        issue_word(instr(1, 0, 1, 0, 0, 31, 1, 0));      // load-use through a store
        issue_word(instr(1, 16, 1, 15, 1, 21, 0, 1));    // alternate bit patterns
        wait_for_results();
    endtask

    task automatic test_random_traffic(int n_words, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < n_words; i++)
        begin
            issue_word(random_instruction());
        end
        wait_for_results();
    endtask

    // Result side stops for a long stretch while instructions keep coming,
    // so the pipe fills and item_ready has to drop.
    task automatic test_backpressure_fill();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < PRESSURE_WORDS; i++)
        begin
            issue_word(random_instruction());
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        result_ready   = 1'b0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        hold_request   = 0;
        hold_left      = 0;
        mismatch_count = 0;
        issued_count   = 0;
        retired_count  = 0;
        for (int i = 0; i < 4; i++)
        begin
            stall_seen[i]  = 0;
            recent_dest[i] = REG_IDX_W'(i + 1);
        end
        clear_scoreboard();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_hazards();
        test_random_traffic(RANDOM_WORDS, 21, 63);
        test_random_traffic(RANDOM_WORDS, 63, 21);
        test_random_traffic(RANDOM_WORDS, 0, 0);
        test_backpressure_fill();

        repeat (10) @(posedge clk);

        $display("Scored %0d instructions, checked %0d timing words, under three idle mixes",
                 issued_count, retired_count);
        $display("Stall counts 0/1/2/3 seen: %0d/%0d/%0d/%0d, plus a %0d-cycle output hold-off",
                 stall_seen[0], stall_seen[1], stall_seen[2], stall_seen[3], HOLD_CYCLES);
        if (mismatch_count == 0 && pending_timings.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/phss_pkg.sv
rtl/phss_regfile.sv
rtl/phss_calc.sv
rtl/pipeline_hazard_stall_scoreboard_unit.sv
dv/pipeline_hazard_stall_scoreboard_unit_tb.sv
